// ----- sv/pfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_pkg: shared types and constants of the pose frame packer
// field widths, saturation limits, fixed-point divide constants, frame codes
// ----------------------------------------------------------------------------
package pfp_pkg;

  localparam int WORD_COUNT = 9;
  localparam int IN_W       = 24;
  localparam int SAT_W      = 18;  // holds +-100005 after the rounding bias
  localparam int MAG_W      = 17;
  localparam int QUO_W      = 14;  // largest quotient is 10000
  localparam int WORD_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int IDX_W      = 5;

  // divide by ten as multiply by ceil(2^20 / 10) and shift, exact below 2^18
  localparam int RECIP_K    = 20;
  localparam int RECIP_W    = 17;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_K) + 9) / 10);

  localparam int ROUND_BIAS = 5;

  // saturation limits per word, in frame order
  localparam int LIM_LO [WORD_COUNT] = '{-100000, -100000, -100000,
                                         -62831, -62831, -62831,
                                         -5000, -5000, 0};
  localparam int LIM_HI [WORD_COUNT] = '{100000, 100000, 100000,
                                         62831, 62831, 62831,
                                         5000, 5000, 10000};

  // frame layout
  localparam int FRAME_LEN = 21;
  localparam int CHECK_BYTES = 9;  // checksum covers payload bytes 0..8
  localparam logic [IDX_W-1:0] IDX_START = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_CHECK = IDX_W'(FRAME_LEN - 2);
  localparam logic [IDX_W-1:0] IDX_END   = IDX_W'(FRAME_LEN - 1);
  localparam logic [BYTE_W-1:0] START_CODE = 8'h24;  // '$'
  localparam logic [BYTE_W-1:0] END_CODE   = 8'h2A;  // '*'

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [QUO_W-1:0]  quo_t;
  typedef logic [IDX_W-1:0]  byte_idx_t;
  typedef logic [WORD_COUNT-1:0][WORD_W-1:0] frame_words_t;

  // register enables handed to the lanes
  typedef struct packed {
    logic load_a;
    logic load_b;
  } lane_en_t;

endpackage

// ----- sv/pfp_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_lane: one value lane
// saturates one input, adds the rounding bias and divides the magnitude by ten
// ----------------------------------------------------------------------------
module pfp_lane #(
  parameter int LANE = 0
) (
  input  logic                             clk,
  input  pfp_pkg::lane_en_t                en,
  input  logic signed [pfp_pkg::IN_W-1:0]  din,
  output pfp_pkg::quo_t                    quo,
  output logic                             neg
);
  import pfp_pkg::*;

  localparam logic signed [IN_W-1:0] LO_V = IN_W'(LIM_LO[LANE]);
  localparam logic signed [IN_W-1:0] HI_V = IN_W'(LIM_HI[LANE]);
  localparam logic signed [SAT_W-1:0] BIAS_V = SAT_W'(ROUND_BIAS);

  logic signed [SAT_W-1:0] sat;
  logic signed [SAT_W-1:0] biased;
  logic [SAT_W-1:0] abs_v;
  logic [MAG_W-1:0] mag_a;
  logic neg_a;
  logic [MAG_W+RECIP_W-1:0] prod;

  always_comb begin
    if (din > HI_V) begin
      sat = HI_V[SAT_W-1:0];
    end else if (din < LO_V) begin
      sat = LO_V[SAT_W-1:0];
    end else begin
      sat = din[SAT_W-1:0];
    end
    biased = sat + BIAS_V;
    abs_v  = biased[SAT_W-1] ? SAT_W'(-biased) : SAT_W'(biased);
  end

  // stage a: magnitude and sign
  always_ff @(posedge clk) begin
    if (en.load_a) begin
      mag_a <= abs_v[MAG_W-1:0];
      neg_a <= biased[SAT_W-1];
    end
  end

  assign prod = mag_a * RECIP;

  // stage b: truncated quotient
  always_ff @(posedge clk) begin
    if (en.load_b) begin
      quo <= prod[RECIP_K +: QUO_W];
      neg <= neg_a;
    end
  end

endmodule

// ----- sv/pfp_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_merge: lane merge
// restores the signs, forms the checksum and holds the frame being sent
// ----------------------------------------------------------------------------
module pfp_merge (
  input  logic                                        clk,
  input  logic                                        load,
  input  pfp_pkg::quo_t [pfp_pkg::WORD_COUNT-1:0]     quo,
  input  logic [pfp_pkg::WORD_COUNT-1:0]              neg,
  output pfp_pkg::frame_words_t                       words,
  output logic [pfp_pkg::BYTE_W-1:0]                  check
);
  import pfp_pkg::*;

  frame_words_t words_next;
  logic [BYTE_W-1:0] sum;

  always_comb begin
    for (int i = 0; i < WORD_COUNT; i++) begin
      words_next[i] = neg[i] ? WORD_W'(-{2'b00, quo[i]}) : WORD_W'({2'b00, quo[i]});
    end
    // sum modulo 256 is enough, only the low byte is sent
    sum = '0;
    for (int b = 0; b < CHECK_BYTES; b++) begin
      sum = sum + words_next[b / 2][(b % 2) * BYTE_W +: BYTE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      words <= words_next;
      check <= ~sum;
    end
  end

endmodule

// ----- sv/pfp_serializer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_serializer: frame byte sequencer
// walks the held frame one byte per accepted output item
// ----------------------------------------------------------------------------
module pfp_serializer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  pfp_pkg::frame_words_t             words,
  input  logic [pfp_pkg::BYTE_W-1:0]        check,
  output logic                              can_load,
  output logic                              tvalid,
  input  logic                              tready,
  output logic [pfp_pkg::BYTE_W-1:0]        tdata,
  output logic                              tlast
);
  import pfp_pkg::*;

  logic busy;
  byte_idx_t idx;
  byte_idx_t off;
  logic [IDX_W-2:0] sel;
  logic xfer;

  assign tvalid   = busy;
  assign tlast    = busy && (idx == IDX_END);
  assign xfer     = busy && tready;
  assign can_load = !busy || (xfer && idx == IDX_END);

  assign off = idx - IDX_W'(1);
  assign sel = off[IDX_W-1:1];

  always_comb begin
    case (idx)
      IDX_START: tdata = START_CODE;
      IDX_CHECK: tdata = check;
      IDX_END:   tdata = END_CODE;
      default: begin
        if (sel < (IDX_W-1)'(WORD_COUNT)) begin
          tdata = off[0] ? words[sel][WORD_W-1:BYTE_W] : words[sel][BYTE_W-1:0];
        end else begin
          tdata = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (xfer) begin
      if (idx == IDX_END) begin
        busy <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  a_load_restarts: assert property (@(posedge clk) disable iff (rst)
    load |=> busy && idx == IDX_START)
    else $error("frame load did not restart at the start byte");

  a_step_by_one: assert property (@(posedge clk) disable iff (rst)
    xfer && idx != IDX_END && !load |=> busy && idx == $past(idx) + IDX_W'(1))
    else $error("byte index did not advance by one");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= IDX_END)
    else $error("byte index past frame end");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> can_load)
    else $error("frame loaded over a frame still in flight");

endmodule

// ----- sv/pose_frame_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_frame_packer: pose to 21-byte serial frame
// nine saturating divide lanes, a merge stage with checksum, a byte sequencer
// ----------------------------------------------------------------------------
// A pose item carries nine 24-bit signed values in 1e-4 units. Each lane clamps
// its value to its range, forms (v+5)/10 truncated toward zero and keeps it as a
// 16-bit word. The frame is '$', the nine words low byte first, the inverted low
// byte of the sum of payload bytes 0..8, and '*' flagged by tlast. Every frame
// is 21 output items, one per cycle while m_axis_tready is high; the byte
// sequencer sets the sustained pose rate. A pose goes through lane stages a
// and b into the frame register; two lane stages and the held frame let two
// more poses be taken while a frame is still going out.
// ----------------------------------------------------------------------------
module pose_frame_packer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, pos_z, yaw_angle, pitch_angle, roll_angle, goal_x, goal_y,
  // goal_z, 24 bits each from the lowest bit up
  input  logic [215:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_byte
  output logic [7:0]   m_axis_tdata,
  // frame_end
  output logic         m_axis_tlast
);
  import pfp_pkg::*;

  logic valid_a;
  logic valid_b;
  logic ready_a;
  logic ready_b;
  logic can_load;
  logic load_c;
  lane_en_t lane_en;
  quo_t [WORD_COUNT-1:0] quo;
  logic [WORD_COUNT-1:0] neg;
  frame_words_t words;
  logic [BYTE_W-1:0] check;

  // pipeline moves when the next stage is free or emptying
  assign load_c  = valid_b && can_load;
  assign ready_b = !valid_b || can_load;
  assign ready_a = !valid_a || ready_b;
  assign s_axis_tready = ready_a;

  assign lane_en.load_a = ready_a;
  assign lane_en.load_b = ready_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a <= s_axis_tvalid;
      end
      if (ready_b) begin
        valid_b <= valid_a;
      end
    end
  end

  // one lane per pose value
  for (genvar g = 0; g < WORD_COUNT; g++) begin : g_lane
    pfp_lane #(
      .LANE (g)
    ) u_lane (
      .clk  (clk),
      .en   (lane_en),
      .din  (s_axis_tdata[g*IN_W +: IN_W]),
      .quo  (quo[g]),
      .neg  (neg[g])
    );
  end

  // signs back on, checksum, frame register
  pfp_merge u_merge (
    .clk   (clk),
    .load  (load_c),
    .quo   (quo),
    .neg   (neg),
    .words (words),
    .check (check)
  );

  // byte sequencer drives the output channel
  pfp_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .load     (load_c),
    .words    (words),
    .check    (check),
    .can_load (can_load),
    .tvalid   (m_axis_tvalid),
    .tready   (m_axis_tready),
    .tdata    (m_axis_tdata),
    .tlast    (m_axis_tlast)
  );

  a_accept_fills_a: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> valid_a)
    else $error("accepted pose not held in lane stage a");

  a_stage_b_held: assert property (@(posedge clk) disable iff (rst)
    valid_b && !can_load |=> valid_b)
    else $error("pose dropped from lane stage b while frame busy");

  a_stage_a_held: assert property (@(posedge clk) disable iff (rst)
    valid_a && !ready_b |=> valid_a)
    else $error("pose dropped from lane stage a while stalled");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the pose frame packer
// drives pose items with random gaps, stalls the byte side at random and checks
// every frame byte and its tlast against a local frame predictor
// ----------------------------------------------------------------------------

import pfp_pkg::*;

// one frame byte as it leaves the block
typedef struct packed {
  logic [BYTE_W-1:0] data;
  logic              last;
} frame_item_t;

// predicts frames from accepted poses and checks the bytes that come out
class frame_scoreboard;
  frame_item_t frame_bytes_due[$];
  int unsigned errors;

  function new();
    errors = 0;
  endfunction

  // mismatch line, printing capped so a broken block cannot flood the log
  task report(string what);
    errors++;
    if (errors <= 40) $display("%0t mismatch: %s", $realtime, what);
  endtask

  // clamp to the lane limits, then (v+5)/10 truncated toward zero
  function word_t pack_word(logic signed [IN_W-1:0] raw, int lane);
    int v;
    int q;
    v = raw;
    if (v > LIM_HI[lane]) v = LIM_HI[lane];
    if (v < LIM_LO[lane]) v = LIM_LO[lane];
    q = (v + ROUND_BIAS) / 10;
    return word_t'(q);
  endfunction

  // accepted pose: queue the 21 bytes of its frame
  function void note_pose(logic [WORD_COUNT*IN_W-1:0] pose);
    logic [BYTE_W-1:0] payload [2*WORD_COUNT];
    logic [15:0]       sum;
    word_t             w;
    frame_item_t       it;
    sum = '0;
    for (int i = 0; i < WORD_COUNT; i++) begin
      w = pack_word(pose[i*IN_W +: IN_W], i);
      payload[2*i]     = w[7:0];
      payload[2*i + 1] = w[15:8];
    end
    // checksum only covers the first nine payload bytes
    for (int i = 0; i < CHECK_BYTES; i++) sum += 16'(payload[i]);
    it.last = 1'b0;
    it.data = START_CODE;
    frame_bytes_due = {frame_bytes_due, it};
    for (int i = 0; i < 2*WORD_COUNT; i++) begin
      it.data = payload[i];
      frame_bytes_due = {frame_bytes_due, it};
    end
    it.data = ~sum[7:0];
    frame_bytes_due = {frame_bytes_due, it};
    it.data = END_CODE;
    it.last = 1'b1;
    frame_bytes_due = {frame_bytes_due, it};
  endfunction

  task check_frame_byte(logic [BYTE_W-1:0] data, logic last);
    frame_item_t due;
    if (frame_bytes_due.size() == 0) begin
      report($sformatf("byte %h with no frame pending", data));
    end else begin
      due = frame_bytes_due.pop_front();
      if (data !== due.data)
        report($sformatf("byte %h, predicted %h", data, due.data));
      if (last !== due.last)
        report($sformatf("tlast %b, predicted %b", last, due.last));
    end
  endtask

  function int outstanding();
    return frame_bytes_due.size();
  endfunction
endclass

module tb_top;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [WORD_COUNT*IN_W-1:0]  s_axis_tdata = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [BYTE_W-1:0]           m_axis_tdata;
  logic                        m_axis_tlast;

  frame_scoreboard sb;
  bit              calm = 1'b0;  // no idling on either side in the closing part

  pose_frame_packer u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  // hard stop well past the slowest legal run
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // byte side: sample at the rising edge
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_frame_byte(m_axis_tdata, m_axis_tlast);
  end

  // byte side back-pressure: random stall bursts between ready runs
  initial begin
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
  end

  // one pose item: optional gap, then hold valid until the handshake
  task send_pose(logic [WORD_COUNT*IN_W-1:0] pose);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = pose;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_pose(pose);
    @(negedge clk);
  endtask

  // hold off until every predicted byte has left the block
  task drain_frames();
    s_axis_tvalid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  function automatic logic [WORD_COUNT*IN_W-1:0] same_pose(int v);
    logic [WORD_COUNT*IN_W-1:0] p;
    for (int i = 0; i < WORD_COUNT; i++) p[i*IN_W +: IN_W] = IN_W'(v);
    return p;
  endfunction

  // every lane at its own limit plus an offset
  function automatic logic [WORD_COUNT*IN_W-1:0] bound_pose(bit high, int offs);
    logic [WORD_COUNT*IN_W-1:0] p;
    for (int i = 0; i < WORD_COUNT; i++)
      p[i*IN_W +: IN_W] = IN_W'((high ? LIM_HI[i] : LIM_LO[i]) + offs);
    return p;
  endfunction

  // field mix: raw patterns, values around the clamp points, in-range, tiny
  function automatic logic [IN_W-1:0] rand_field(int lane);
    int span;
    int v;
    span = LIM_HI[lane] - LIM_LO[lane];
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom);
      4, 5: v = ($urandom_range(0, 1) ? LIM_HI[lane] : LIM_LO[lane])
                + int'($urandom_range(0, 60)) - 30;
      6, 7, 8: v = LIM_LO[lane] + int'($urandom_range(0, span));
      default: v = int'($urandom_range(0, 80)) - 40;
    endcase
    return IN_W'(v);
  endfunction

  initial begin
    logic [WORD_COUNT*IN_W-1:0] pose;
    sb = new();
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed: zero, raw extremes, limits and one past, rounding points
    send_pose(same_pose(0));
    send_pose(same_pose(8388607));
    send_pose(same_pose(-8388608));
    send_pose(same_pose(-1));
    send_pose(same_pose(1));
    send_pose(bound_pose(1'b1, 0));
    send_pose(bound_pose(1'b0, 0));
    send_pose(bound_pose(1'b1, 1));
    send_pose(bound_pose(1'b0, -1));
    send_pose(bound_pose(1'b1, -1));
    send_pose(bound_pose(1'b0, 1));
    send_pose(bound_pose(1'b1, -5));
    send_pose(bound_pose(1'b0, 5));
    // rounding bias across zero: -5, -6, -15, -16 and the positive steps
    send_pose(same_pose(-5));
    send_pose(same_pose(-6));
    send_pose(same_pose(-15));
    send_pose(same_pose(-16));
    send_pose(same_pose(4));
    send_pose(same_pose(5));
    send_pose(same_pose(14));
    send_pose(same_pose(15));
    // high bytes all ones make the checksum sum wrap past 8 bits
    send_pose(same_pose(-2560));
    drain_frames();

    for (int n = 0; n < 350; n++) begin
      if (n == 290) calm = 1'b1;
      if (n == 120 || n == 200) drain_frames();
      for (int i = 0; i < WORD_COUNT; i++) pose[i*IN_W +: IN_W] = rand_field(i);
      send_pose(pose);
    end

    drain_frames();
    repeat (40) @(negedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/pfp_pkg.sv
sv/pfp_lane.sv
sv/pfp_merge.sv
sv/pfp_serializer.sv
sv/pose_frame_packer.sv
tb/tb_top.sv
